// ===== sv/rpn_pkg.sv =====
package rpn_pkg;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_END  = 3'd5
	} op_code_t;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_DIV0      = 3'd1;
	localparam logic [2:0] ST_OPERATORS = 3'd2;
	localparam logic [2:0] ST_OPERANDS  = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] operand;
	} token_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] top_value;
		logic [6:0]  stack_depth;
	} result_t;

	localparam int DIV_BITS = 48;

endpackage

// ===== sv/rpn_ram.sv =====
module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/rpn_fifo.sv =====
module rpn_fifo #(
	parameter int WIDTH = 35
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] buf_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full)
			buf_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !full)
				wp_q <= ~wp_q;
			if (rd && !empty)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
		end
	end

endmodule

// ===== sv/rpn_divider.sv =====
module rpn_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] quot
);
	import rpn_pkg::*;

	logic [DIV_BITS-1:0] num_q, quo_q;
	logic [31:0]         den_q;
	logic [32:0]         rem_q;
	logic [5:0]          cnt_q;
	logic                neg_q, busy_q;
	logic [32:0]         shifted, diff;
	logic [DIV_BITS:0]   sq;
	logic [47:0]         na;
	logic [31:0]         nb;

	assign na      = a[31] ? 48'(-{{16{a[31]}}, a}) << 16 : 48'({16'd0, a}) << 16;
	assign nb      = b[31] ? -b : b;
	assign shifted = {rem_q[31:0], num_q[DIV_BITS-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign sq      = neg_q ? {1'b0, -quo_q} : {1'b0, quo_q};

	always_comb begin
		if (!neg_q && quo_q > 48'h0000_7FFF_FFFF)
			quot = 32'h7FFF_FFFF;
		else if (neg_q && quo_q > 48'h0000_8000_0000)
			quot = 32'h8000_0000;
		else
			quot = sq[31:0];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= na;
			den_q <= nb;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= a[31] ^ b[31];
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= !start && busy_q && cnt_q == '0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIV_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0)
					busy_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/rpn_exec.sv =====
module rpn_exec #(
	parameter int STACK_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tok_valid,
	input  rpn_pkg::token_t  tok,
	output logic             tok_take,
	output logic             res_valid,
	output rpn_pkg::result_t res,
	input  logic             res_full
);
	import rpn_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RDB   = 7'b0000010,
		S_RDA   = 7'b0000100,
		S_CALC  = 7'b0001000,
		S_MUL   = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t      state_q;
	logic [CW-1:0] cnt_q;
	logic        abort_q;
	logic [31:0] top_q, b_q, r_q;
	logic [2:0]  op_q;
	logic signed [63:0] prod_q;
	logic        we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0] wdata, rdata;
	logic        dstart, ddone;
	logic [31:0] dq;
	logic signed [47:0] ps;

	rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	rpn_divider u_div (
		.clk, .arst_n, .start(dstart), .a(rdata), .b(b_q), .done(ddone), .quot(dq)
	);

	assign tok_take  = state_q == S_IDLE && tok_valid;
	assign res_valid = state_q == S_OUT;
	assign ps        = 48'(prod_q >>> 16);

	always_comb begin
		we    = 1'b0;
		waddr = AW'(cnt_q);
		wdata = tok.operand;
		raddr = AW'(cnt_q - CW'(2));
		if (tok_take && !abort_q && tok.op == OP_PUSH && cnt_q < CW'(STACK_DEPTH))
			we = 1'b1;
		if (state_q == S_RDB && !res_full) begin
			we    = 1'b1;
			waddr = AW'(cnt_q - CW'(2));
			wdata = r_q;
		end
		dstart = state_q == S_CALC && op_q == OP_DIV;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RDA)
			b_q <= top_q;
		if (state_q == S_CALC)
			prod_q <= $signed(rdata) * $signed(top_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			abort_q   <= 1'b0;
			top_q     <= '0;
			res       <= '0;
			op_q      <= '0;
			r_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (tok_valid) begin
						op_q <= tok.op;
						if (tok.op == OP_END) begin
							res <= '{(!abort_q && cnt_q != CW'(1)) ? ST_OPERANDS : ST_OK,
								abort_q ? 32'd0 : top_q, 7'd0};
							cnt_q <= '0;
							top_q <= '0;
							abort_q <= 1'b0;
							state_q <= S_OUT;
						end else if (abort_q || tok.op > OP_END) begin
							res <= '{ST_OK, top_q, 7'(cnt_q)};
							state_q <= S_OUT;
						end else if (tok.op == OP_PUSH) begin
							state_q <= S_OUT;
							if (cnt_q >= CW'(STACK_DEPTH)) begin
								abort_q <= 1'b1;
								res <= '{ST_OVERFLOW, top_q, 7'(cnt_q)};
							end else begin
								cnt_q <= cnt_q + CW'(1);
								top_q <= tok.operand;
								res <= '{ST_OK, tok.operand, 7'(cnt_q + CW'(1))};
							end
						end else if (tok.op == OP_DIV && cnt_q != '0 && top_q == '0) begin
							abort_q <= 1'b1;
							res <= '{ST_DIV0, top_q, 7'(cnt_q)};
							state_q <= S_OUT;
						end else if (cnt_q < CW'(2)) begin
							abort_q <= 1'b1;
							res <= '{ST_OPERATORS, top_q, 7'(cnt_q)};
							state_q <= S_OUT;
						end else begin
							state_q <= S_RDA;
						end
					end
				end
				S_RDA: state_q <= S_CALC;
				S_CALC: begin
					case (op_q)
						OP_ADD: begin r_q <= rdata + top_q; state_q <= S_RDB; end
						OP_SUB: begin r_q <= rdata - top_q; state_q <= S_RDB; end
						OP_MUL: state_q <= S_MUL;
						default: state_q <= S_DIV;
					endcase
				end
				S_MUL: begin
					if (ps > 48'sh7FFF_FFFF)
						r_q <= 32'h7FFF_FFFF;
					else if (ps < -48'sh8000_0000)
						r_q <= 32'h8000_0000;
					else
						r_q <= ps[31:0];
					state_q <= S_RDB;
				end
				S_DIV: begin
					if (ddone) begin
						r_q <= dq;
						state_q <= S_RDB;
					end
				end
				S_RDB: begin
					if (!res_full) begin
						cnt_q <= cnt_q - CW'(1);
						top_q <= r_q;
						res <= '{ST_OK, r_q, 7'(cnt_q - CW'(1))};
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!res_full)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/rpn_stack_evaluator.sv =====
// RPN evaluator over a bounded Q16.16 operand stack.
// Input channel: push/full with op and operand; one beat per token.
// Result channel: empty/pop with status, top_value, stack_depth; one beat
// per token, in token order.
// A two-entry token queue feeds the executor; a two-entry result queue
// drains it, so either side may stall without losing beats.
// Push, end, ignored and error tokens go from idle straight to the output
// state; add and subtract go through RDA, CALC and RDB; multiply adds MUL;
// divide waits in DIV on the one-bit-per-cycle 48-step restoring divider.
// A new token is taken only after the last result beat leaves the executor.
// The stack lives in a RAM with registered read; the top entry is kept in
// a register, and the entry below it is read when an operator arrives.
// Reset clears depth, abort mark and both queues; stack contents are not
// cleared, since only written entries are read.
// When the result queue is full the executor holds its result and stops
// taking tokens; the token queue then fills and raises full.
module rpn_stack_evaluator #(
	parameter int STACK_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  op,
	input  logic signed [31:0] operand,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic signed [31:0] top_value,
	output logic [6:0]  stack_depth
);
	import rpn_pkg::*;

	token_t  tin, tout;
	result_t rin, rout;
	logic    tempty, take, rvalid, rfull;

	assign tin = '{op, operand};

	rpn_fifo #(.WIDTH($bits(token_t))) u_tq (
		.clk, .arst_n, .wr(push), .wdata(tin), .full,
		.rd(take), .rdata(tout), .empty(tempty)
	);

	rpn_exec #(.STACK_DEPTH(STACK_DEPTH)) u_exec (
		.clk, .arst_n, .tok_valid(!tempty), .tok(tout), .tok_take(take),
		.res_valid(rvalid), .res(rin), .res_full(rfull)
	);

	rpn_fifo #(.WIDTH($bits(result_t))) u_rq (
		.clk, .arst_n, .wr(rvalid), .wdata(rin), .full(rfull),
		.rd(pop), .rdata(rout), .empty
	);

	assign status      = rout.status;
	assign top_value   = rout.top_value;
	assign stack_depth = rout.stack_depth;

endmodule

// ===== sv/rpn_checker.sv =====
module rpn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  status,
	input logic [31:0] top_value,
	input logic [6:0]  stack_depth
);
	import rpn_pkg::*;

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> status <= ST_OVERFLOW) else $error("bad status");
	a_err_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_OVERFLOW) |-> stack_depth != 7'd0)
		else $error("overflow at zero");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(top_value))) else $error("result lost");
	a_rst: assert property (@(posedge clk) !arst_n |-> empty) else $error("not empty");

endmodule

bind rpn_stack_evaluator rpn_checker u_chk (.*);

// ===== test/tb_rpn_stack_evaluator.sv =====
`timescale 1ns / 1ps

module tb_rpn_stack_evaluator;
	import rpn_pkg::*;

	localparam int DEPTH = 64;

	class rpn_scoreboard;
		logic [31:0] stack_mem [DEPTH];
		int unsigned entries;
		bit aborted;
		result_t pending [$];
		int mismatches;

		function new();
			entries = 0;
			aborted = 0;
			mismatches = 0;
		endfunction

		function logic [31:0] top_entry();
			if (entries == 0)
				return 32'd0;
			return stack_mem[entries-1];
		endfunction

		function logic [31:0] clamp(logic signed [63:0] v);
			if (v > 64'sd2147483647)
				return 32'h7fffffff;
			if (v < -64'sd2147483648)
				return 32'h80000000;
			return v[31:0];
		endfunction

		function logic [31:0] q_mul(logic [31:0] a, logic [31:0] b);
			logic signed [63:0] p;
			p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
			return clamp(p >>> 16);
		endfunction

		function logic [31:0] q_div(logic [31:0] a, logic [31:0] b);
			logic signed [63:0] n;
			logic signed [63:0] d;
			n = $signed({{32{a[31]}}, a}) <<< 16;
			d = $signed({{32{b[31]}}, b});
			return clamp(n / d);
		endfunction

		function void note_token(logic [2:0] code, logic [31:0] val);
			result_t r;
			logic [31:0] a;
			logic [31:0] b;
			logic [31:0] res;
			r.status = ST_OK;
			if (code == OP_END) begin
				r.top_value = 32'd0;
				if (!aborted) begin
					r.top_value = top_entry();
					if (entries != 1)
						r.status = ST_OPERANDS;
				end
				entries = 0;
				aborted = 0;
				r.stack_depth = 7'd0;
				pending.push_back(r);
				return;
			end
			if (!aborted && code <= OP_DIV) begin
				if (code == OP_PUSH) begin
					if (entries >= DEPTH)
						r.status = ST_OVERFLOW;
					else begin
						stack_mem[entries] = val;
						entries++;
					end
				end else if (code == OP_DIV && entries >= 1 && top_entry() == 0)
					r.status = ST_DIV0;
				else if (entries < 2)
					r.status = ST_OPERATORS;
				else begin
					b = stack_mem[entries-1];
					a = stack_mem[entries-2];
					case (code)
						OP_ADD: res = a + b;
						OP_SUB: res = a - b;
						OP_MUL: res = q_mul(a, b);
						default: res = q_div(a, b);
					endcase
					entries--;
					stack_mem[entries-1] = res;
				end
				if (r.status != ST_OK)
					aborted = 1;
			end
			r.top_value = top_entry();
			r.stack_depth = entries[6:0];
			pending.push_back(r);
		endfunction

		function void check_beat(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat st=%0d top=%h d=%0d",
						got.status, got.top_value, got.stack_depth);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp st=%0d top=%h d=%0d got st=%0d top=%h d=%0d",
						want.status, want.top_value, want.stack_depth,
						got.status, got.top_value, got.stack_depth);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [2:0] op;
	logic signed [31:0] operand;
	logic empty;
	logic pop;
	logic [2:0] status;
	logic signed [31:0] top_value;
	logic [6:0] stack_depth;

	rpn_scoreboard sb;
	bit calm;
	int sent;

	rpn_stack_evaluator dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .op(op),
		.operand(operand), .empty(empty), .pop(pop), .status(status),
		.top_value(top_value), .stack_depth(stack_depth)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function logic [31:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'd0;
			3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
			4, 5: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
			default: return $urandom;
		endcase
	endfunction

	task send(logic [2:0] code, logic [31:0] val);
		while (!calm && $urandom_range(0, 99) < 6) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		op <= code;
		operand <= val;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_token(code, val);
		sent++;
	endtask

	task send_expression();
		int depth;
		int n;
		depth = 0;
		n = $urandom_range(1, 8);
		while (n > 0 || depth > 1) begin
			if (depth < 2 || (n > 0 && $urandom_range(0, 1))) begin
				send(OP_PUSH, rand_value());
				depth++;
				n--;
			end else begin
				send(3'($urandom_range(OP_ADD, OP_DIV)), 0);
				depth--;
			end
		end
		if ($urandom_range(0, 9) == 0)
			send(3'($urandom_range(0, 7)), $urandom);
		send(OP_END, $urandom);
	endtask

	initial begin
		sb = new();
		sent = 0;
		calm = 0;
		arst_n = 1;
		push = 0;
		pop = 0;
		op = OP_PUSH;
		operand = 0;
		#1 arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send(OP_END, 0);
		send(OP_ADD, 0);
		send(OP_END, 0);
		send(OP_DIV, 0);
		send(OP_END, 0);
		send(OP_PUSH, 32'h7fffffff);
		send(OP_PUSH, 32'h7fffffff);
		send(OP_MUL, 0);
		send(OP_PUSH, 32'h80000000);
		send(OP_ADD, 0);
		send(OP_PUSH, 32'h00000001);
		send(OP_DIV, 0);
		send(OP_PUSH, 32'h00000000);
		send(OP_DIV, 0);
		send(OP_PUSH, 32'h5);
		send(OP_END, 0);
		send(3'd6, 32'hffffffff);
		send(3'd7, 0);
		send(OP_PUSH, 32'h00030000);
		send(OP_PUSH, 32'h00010000);
		send(OP_SUB, 0);
		send(OP_PUSH, 32'h80000000);
		send(OP_MUL, 0);
		send(OP_END, 0);
		for (int i = 0; i < DEPTH + 1; i++)
			send(OP_PUSH, $urandom);
		send(OP_END, 0);
		push <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		while (sent < 1600) begin
			calm = (sent > 700 && sent < 950);
			if ($urandom_range(0, 9) == 0)
				send(3'($urandom_range(0, 7)), rand_value());
			else
				send_expression();
		end
		push <= 1'b0;
		calm = 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_beat('{status, top_value, stack_depth});
			pop <= calm || $urandom_range(0, 99) >= 6;
		end
	end
endmodule

// ===== filelist.f =====
sv/rpn_pkg.sv
sv/rpn_ram.sv
sv/rpn_fifo.sv
sv/rpn_divider.sv
sv/rpn_exec.sv
sv/rpn_stack_evaluator.sv
sv/rpn_checker.sv
test/tb_rpn_stack_evaluator.sv
